// ===== src/rctu_pkg.sv =====
// Shared types and constants for the RV32 CSR and trap unit.
// No dependencies.
package rctu_pkg;

  localparam logic [3:0] OP_READ  = 4'd0;
  localparam logic [3:0] OP_WRITE = 4'd1;
  localparam logic [3:0] OP_SET   = 4'd2;
  localparam logic [3:0] OP_CLEAR = 4'd3;
  localparam logic [3:0] OP_TRAP  = 4'd4;
  localparam logic [3:0] OP_MRET  = 4'd5;
  localparam logic [3:0] OP_SRET  = 4'd6;
  localparam logic [3:0] OP_TVAL  = 4'd7;
  localparam logic [3:0] OP_TICK  = 4'd8;

  localparam logic [1:0] PRV_U = 2'd0;
  localparam logic [1:0] PRV_S = 2'd1;
  localparam logic [1:0] PRV_M = 2'd3;

  localparam logic [31:0] MISA_VAL   = 32'h4010_1105;
  localparam logic [31:0] TVEC_MASK  = 32'hffff_fffd;
  localparam logic [31:0] EPC_MASK   = 32'hffff_fffe;
  localparam logic [31:0] CAUSE_MASK = 32'h8000_00ff;
  localparam logic [31:0] CNTEN_MASK = 32'h0000_0007;
  localparam logic [31:0] SATP_MASK  = 32'h803f_ffff;
  localparam logic [31:0] SMASK      = 32'h000c_0122;
  localparam logic [31:0] MMASK      = 32'h007c_19aa;
  localparam logic [4:0]  CAUSE_ILLEGAL = 5'd2;

  // decoded transaction handed from front to back
  typedef struct packed {
    logic [3:0]  mode;
    logic [11:0] addr;
    logic [31:0] wdata;
    logic [4:0]  code;
    logic        intr;
    logic [31:0] pc;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] rdata;
    logic [31:0] target_pc;
  } res_t;

endpackage

// ===== src/riscv_csr_trap_unit.sv =====
// RV32 M/S CSR file with trap entry and return.
// Path: an accepted transaction is written into the queue, then the CSR stage registers its result.
// Throughput: one transaction per cycle; the CSR stage updates state and
// registers the result in the same cycle, and a two-entry queue absorbs stalls.
// Reset (rst_n low, synchronous): machine mode, all CSRs and counters zero,
// queue and output empty.
module riscv_csr_trap_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [11:0] in_csr_addr,
  input  logic [31:0] in_wdata,
  input  logic [4:0]  in_cause_code,
  input  logic        in_is_interrupt,
  input  logic [31:0] in_pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [31:0] out_rdata,
  output logic [31:0] out_target_pc
);
  import rctu_pkg::*;

  item_t in_item, q_item;
  res_t  res;
  logic  q_valid, q_pop;

  assign in_item = '{mode: in_mode, addr: in_csr_addr, wdata: in_wdata,
                     code: in_cause_code, intr: in_is_interrupt, pc: in_pc};

  rctu_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  rctu_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign out_ok        = res.ok;
  assign out_rdata     = res.rdata;
  assign out_target_pc = res.target_pc;
endmodule

// ===== src/rctu_front.sv =====
// Front end: two-entry queue that registers accepted transactions.
// Depends on rctu_pkg.
module rctu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rctu_pkg::item_t      in_item,
  output logic                 q_valid,
  input  logic                 q_pop,
  output rctu_pkg::item_t      q_item
);
  import rctu_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule

// ===== src/rctu_back.sv =====
// Back end: CSR state, access checks, trap entry and return; registered result.
// Depends on rctu_pkg.
module rctu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  rctu_pkg::item_t   q_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rctu_pkg::res_t    out_res
);
  import rctu_pkg::*;

  logic [1:0]  prv_r, prv_nxt;
  logic [31:0] st_r, st_nxt;
  logic [31:0] mie_r, mip_r, mtvec_r, mscr_r, mepc_r, mcause_r, mtval_r;
  logic [31:0] medeleg_r, mideleg_r, mcnten_r;
  logic [31:0] sie_r, sip_r, stvec_r, scnten_r, sscr_r, sepc_r, scause_r, stval_r, satp_r;
  logic [31:0] mie_n, mtvec_n, mscr_n, mepc_n, mcause_n, mtval_n;
  logic [31:0] medeleg_n, mideleg_n, mcnten_n;
  logic [31:0] sie_n, stvec_n, scnten_n, sscr_n, sepc_n, scause_n, stval_n, satp_n;
  logic [63:0] cyc_r, cyc_nxt, ret_r, ret_nxt;
  logic        ov_r;
  res_t        res_r, res_nxt;

  logic        fire;
  logic        rd_ok, wr_ok, pc_ok, pi_ok, satp_ok, do_trap;
  logic [31:0] rv, d;
  logic [4:0]  t_code;
  logic        t_intr;
  logic [31:0] deleg, tvec, s;
  logic [1:0]  tgt;
  logic [11:0] a;

  assign fire      = q_valid && (!ov_r || !out_stall);
  assign q_pop     = fire;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign a         = q_item.addr;

  // read decode, shared by read/set/clear
  always_comb begin
    pc_ok = (prv_r >= PRV_M || mcnten_r[0]) && (prv_r >= PRV_S || scnten_r[0]);
    pi_ok = (prv_r >= PRV_M || mcnten_r[2]) && (prv_r >= PRV_S || scnten_r[2]);
    satp_ok = (prv_r >= PRV_M) || !st_r[20];
    rd_ok = 1'b1;
    rv = '0;
    unique case (a)
      12'h301: rv = MISA_VAL;
      12'hf11, 12'hf12, 12'hf13, 12'hf14: rv = '0;
      12'h300: rv = st_r & MMASK;
      12'h304: rv = mie_r;
      12'h344: rv = mip_r;
      12'h305: rv = mtvec_r;
      12'h340: rv = mscr_r;
      12'h341: rv = mepc_r;
      12'h342: rv = mcause_r;
      12'h343: rv = mtval_r;
      12'h302: rv = medeleg_r;
      12'h303: rv = mideleg_r;
      12'h306: rv = mcnten_r;
      12'hb00: rv = cyc_r[31:0];
      12'hb80: rv = cyc_r[63:32];
      12'hb02: rv = ret_r[31:0];
      12'hb82: rv = ret_r[63:32];
      12'h100: rv = st_r & SMASK;
      12'h104: rv = sie_r;
      12'h144: rv = sip_r;
      12'h105: rv = stvec_r;
      12'h106: rv = scnten_r;
      12'h140: rv = sscr_r;
      12'h141: rv = sepc_r;
      12'h142: rv = scause_r;
      12'h143: rv = stval_r;
      12'h180: begin rd_ok = satp_ok; rv = satp_r; end
      12'hc00: begin rd_ok = pc_ok; rv = cyc_r[31:0]; end
      12'hc80: begin rd_ok = pc_ok; rv = cyc_r[63:32]; end
      12'hc02: begin rd_ok = pi_ok; rv = ret_r[31:0]; end
      12'hc82: begin rd_ok = pi_ok; rv = ret_r[63:32]; end
      default: rd_ok = 1'b0;
    endcase
    if (a[9:8] > prv_r) rd_ok = 1'b0;
  end

  always_comb begin
    prv_nxt = prv_r; st_nxt = st_r;
    mie_n = mie_r; mtvec_n = mtvec_r; mscr_n = mscr_r; mepc_n = mepc_r;
    mcause_n = mcause_r; mtval_n = mtval_r; medeleg_n = medeleg_r;
    mideleg_n = mideleg_r; mcnten_n = mcnten_r;
    sie_n = sie_r; stvec_n = stvec_r; scnten_n = scnten_r; sscr_n = sscr_r;
    sepc_n = sepc_r; scause_n = scause_r; stval_n = stval_r; satp_n = satp_r;
    cyc_nxt = cyc_r; ret_nxt = ret_r;
    res_nxt = '0;
    do_trap = 1'b0;
    t_code = q_item.code;
    t_intr = q_item.intr;
    wr_ok = 1'b0;
    d = q_item.wdata;
    deleg = '0; tvec = '0; s = '0; tgt = PRV_M;
    case (q_item.mode)
      OP_READ: begin
        res_nxt.ok = rd_ok;
        res_nxt.rdata = rd_ok ? rv : 32'd0;
      end
      OP_WRITE, OP_SET, OP_CLEAR: begin
        wr_ok = !(a[9:8] > prv_r) && (a[11:10] != 2'd3);
        if (q_item.mode == OP_SET) begin
          wr_ok = wr_ok && rd_ok; d = rv | q_item.wdata;
        end else if (q_item.mode == OP_CLEAR) begin
          wr_ok = wr_ok && rd_ok; d = rv & ~q_item.wdata;
        end
        if (wr_ok) begin
          unique case (a)
            12'h301, 12'h344, 12'h144: ;
            12'h300: begin
              st_nxt = d & MMASK;
              if (st_nxt[12:11] == 2'd2) st_nxt[12:11] = 2'd0;
            end
            12'h304: mie_n = d;
            12'h305: mtvec_n = d & TVEC_MASK;
            12'h340: mscr_n = d;
            12'h341: mepc_n = d & EPC_MASK;
            12'h342: mcause_n = d & CAUSE_MASK;
            12'h343: mtval_n = d;
            12'h302: medeleg_n = d;
            12'h303: mideleg_n = d;
            12'h306: mcnten_n = d & CNTEN_MASK;
            12'hb00: cyc_nxt[31:0] = d;
            12'hb80: cyc_nxt[63:32] = d;
            12'hb02: ret_nxt[31:0] = d;
            12'hb82: ret_nxt[63:32] = d;
            12'h100: st_nxt = (d & SMASK) | (st_r & ~SMASK);
            12'h104: sie_n = d;
            12'h105: stvec_n = d & TVEC_MASK;
            12'h106: scnten_n = d & CNTEN_MASK;
            12'h140: sscr_n = d;
            12'h141: sepc_n = d & EPC_MASK;
            12'h142: scause_n = d & CAUSE_MASK;
            12'h143: stval_n = d;
            12'h180: begin
              if (satp_ok) satp_n = d & SATP_MASK;
              else wr_ok = 1'b0;
            end
            default: wr_ok = 1'b0;
          endcase
        end
        res_nxt.ok = wr_ok;
      end
      OP_TRAP: begin
        do_trap = 1'b1;
        res_nxt.ok = 1'b1;
      end
      OP_MRET: begin
        if (prv_r != PRV_M) begin
          do_trap = 1'b1; t_code = CAUSE_ILLEGAL; t_intr = 1'b0;
        end else begin
          st_nxt = st_r;
          st_nxt[3] = st_r[7];
          st_nxt[7] = 1'b1;
          st_nxt[12:11] = 2'd0;
          prv_nxt = (st_r[12:11] == 2'd2) ? PRV_U : st_r[12:11];
          res_nxt.target_pc = mepc_r;
          res_nxt.ok = 1'b1;
        end
      end
      OP_SRET: begin
        if (prv_r == PRV_U || (prv_r == PRV_S && st_r[22])) begin
          do_trap = 1'b1; t_code = CAUSE_ILLEGAL; t_intr = 1'b0;
        end else begin
          st_nxt = st_r;
          st_nxt[1] = st_r[5];
          st_nxt[5] = 1'b1;
          st_nxt[8] = 1'b0;
          prv_nxt = {1'b0, st_r[8]};
          res_nxt.target_pc = sepc_r;
          res_nxt.ok = 1'b1;
        end
      end
      OP_TVAL: begin
        if (prv_r == PRV_S) stval_n = q_item.wdata;
        else mtval_n = q_item.wdata;
        res_nxt.ok = 1'b1;
      end
      OP_TICK: begin
        cyc_nxt = cyc_r + 64'd1;
        ret_nxt = ret_r + 64'd1;
        res_nxt.ok = 1'b1;
      end
      default: ;
    endcase

    if (do_trap) begin
      deleg = t_intr ? mideleg_r : medeleg_r;
      tgt = deleg[t_code] ? PRV_S : PRV_M;
      if (tgt < prv_r) tgt = prv_r;
      if (tgt == PRV_M) begin
        s = st_r;
        s[12:11] = prv_r;
        s[7] = st_r[3];
        s[3] = 1'b0;
        mcause_n = {t_intr, 26'd0, t_code};
        mepc_n = q_item.pc & EPC_MASK;
        tvec = mtvec_r;
      end else begin
        s = st_r;
        s[8] = prv_r[0];
        s[5] = st_r[1];
        s[1] = 1'b0;
        scause_n = {t_intr, 26'd0, t_code};
        sepc_n = q_item.pc & EPC_MASK;
        tvec = stvec_r;
      end
      st_nxt = s;
      prv_nxt = tgt;
      res_nxt.target_pc = (tvec & EPC_MASK) +
                          ((tvec[0] && t_intr) ? {25'd0, t_code, 2'b00} : 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      prv_r <= PRV_M; st_r <= '0;
      mie_r <= '0; mip_r <= '0; mtvec_r <= '0; mscr_r <= '0; mepc_r <= '0;
      mcause_r <= '0; mtval_r <= '0; medeleg_r <= '0; mideleg_r <= '0; mcnten_r <= '0;
      sie_r <= '0; sip_r <= '0; stvec_r <= '0; scnten_r <= '0; sscr_r <= '0;
      sepc_r <= '0; scause_r <= '0; stval_r <= '0; satp_r <= '0;
      cyc_r <= '0; ret_r <= '0;
    end else begin
      if (fire) begin
        ov_r <= 1'b1;
        prv_r <= prv_nxt; st_r <= st_nxt;
        mie_r <= mie_n; mtvec_r <= mtvec_n; mscr_r <= mscr_n; mepc_r <= mepc_n;
        mcause_r <= mcause_n; mtval_r <= mtval_n; medeleg_r <= medeleg_n;
        mideleg_r <= mideleg_n; mcnten_r <= mcnten_n;
        sie_r <= sie_n; stvec_r <= stvec_n; scnten_r <= scnten_n; sscr_r <= sscr_n;
        sepc_r <= sepc_n; scause_r <= scause_n; stval_r <= stval_n; satp_r <= satp_n;
        cyc_r <= cyc_nxt; ret_r <= ret_nxt;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res_nxt;
  end
endmodule

// ===== dv/riscv_csr_trap_unit_tb.sv =====
// Self-checking testbench for riscv_csr_trap_unit: directed and random CSR accesses,
// traps, returns, tval writes and counter ticks, checked against an in-bench predictor.
// Depends on rctu_pkg and the riscv_csr_trap_unit RTL.
module riscv_csr_trap_unit_tb;
  import rctu_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_mode;
  logic [11:0] in_csr_addr;
  logic [31:0] in_wdata;
  logic [4:0]  in_cause_code;
  logic        in_is_interrupt;
  logic [31:0] in_pc;
  logic        out_valid;
  logic        out_stall;
  logic        out_ok;
  logic [31:0] out_rdata;
  logic [31:0] out_target_pc;

  riscv_csr_trap_unit i_dut (.*);

  // csr address map
  localparam logic [11:0] A_SSTATUS = 12'h100, A_SIE = 12'h104, A_STVEC = 12'h105,
    A_SCNTEN = 12'h106, A_SSCRATCH = 12'h140, A_SEPC = 12'h141, A_SCAUSE = 12'h142,
    A_STVAL = 12'h143, A_SIP = 12'h144, A_SATP = 12'h180,
    A_MSTATUS = 12'h300, A_MISA = 12'h301, A_MEDELEG = 12'h302, A_MIDELEG = 12'h303,
    A_MIE = 12'h304, A_MTVEC = 12'h305, A_MCNTEN = 12'h306, A_MSCRATCH = 12'h340,
    A_MEPC = 12'h341, A_MCAUSE = 12'h342, A_MTVAL = 12'h343, A_MIP = 12'h344,
    A_MCYCLE = 12'hB00, A_MINSTRET = 12'hB02, A_MCYCLEH = 12'hB80, A_MINSTRETH = 12'hB82,
    A_CYCLE = 12'hC00, A_INSTRET = 12'hC02, A_CYCLEH = 12'hC80, A_INSTRETH = 12'hC82,
    A_MVENDOR = 12'hF11, A_MHARTID = 12'hF14;

  localparam logic [31:0] ST_SIE = 32'h2, ST_MIE = 32'h8, ST_SPIE = 32'h20,
    ST_MPIE = 32'h80, ST_SPP = 32'h100, ST_MPP = 32'h1800, ST_TVM = 32'h100000,
    ST_TSR = 32'h400000;

  localparam logic [11:0] CSR_LIST [32] = '{A_SSTATUS, A_SIE, A_STVEC, A_SCNTEN, A_SSCRATCH,
    A_SEPC, A_SCAUSE, A_STVAL, A_SIP, A_SATP, A_MSTATUS, A_MISA, A_MEDELEG, A_MIDELEG,
    A_MIE, A_MTVEC, A_MCNTEN, A_MSCRATCH, A_MEPC, A_MCAUSE, A_MTVAL, A_MIP, A_MCYCLE,
    A_MINSTRET, A_MCYCLEH, A_MINSTRETH, A_CYCLE, A_INSTRET, A_CYCLEH, A_INSTRETH,
    A_MVENDOR, A_MHARTID};

  // predictor state
  logic [1:0]  prv;
  logic [31:0] mstat;
  logic [31:0] m_ie, m_tvec, m_scratch, m_epc, m_cause, m_tval, m_edeleg, m_ideleg, m_cnten;
  logic [31:0] s_ie, s_tvec, s_cnten, s_scratch, s_epc, s_cause, s_tval, s_atp;
  logic [63:0] cyc_cnt, ret_cnt;

  item_t pending_q[$];
  res_t  expected_q[$];
  int    errors;
  int    cycle;
  int    in_idle_pct, out_stall_pct;

  function automatic bit csr_fetch(input logic [11:0] a, output logic [31:0] v);
    bit cy_ok, ir_ok, atp_ok;
    cy_ok = (prv >= 3 || m_cnten[0]) && (prv >= 1 || s_cnten[0]);
    ir_ok = (prv >= 3 || m_cnten[2]) && (prv >= 1 || s_cnten[2]);
    atp_ok = prv >= 3 || !(mstat & ST_TVM);
    v = '0;
    if (a[9:8] > prv) return 0;
    case (a)
      A_MISA:      v = MISA_VAL;
      12'hF11, 12'hF12, 12'hF13, 12'hF14: v = '0;
      A_MSTATUS:   v = mstat & MMASK;
      A_MIE:       v = m_ie;
      A_MIP:       v = '0;
      A_MTVEC:     v = m_tvec;
      A_MSCRATCH:  v = m_scratch;
      A_MEPC:      v = m_epc;
      A_MCAUSE:    v = m_cause;
      A_MTVAL:     v = m_tval;
      A_MEDELEG:   v = m_edeleg;
      A_MIDELEG:   v = m_ideleg;
      A_MCNTEN:    v = m_cnten;
      A_MCYCLE:    v = cyc_cnt[31:0];
      A_MCYCLEH:   v = cyc_cnt[63:32];
      A_MINSTRET:  v = ret_cnt[31:0];
      A_MINSTRETH: v = ret_cnt[63:32];
      A_SSTATUS:   v = mstat & SMASK;
      A_SIE:       v = s_ie;
      A_SIP:       v = '0;
      A_STVEC:     v = s_tvec;
      A_SCNTEN:    v = s_cnten;
      A_SSCRATCH:  v = s_scratch;
      A_SEPC:      v = s_epc;
      A_SCAUSE:    v = s_cause;
      A_STVAL:     v = s_tval;
      A_SATP:      begin if (!atp_ok) return 0; v = s_atp; end
      A_CYCLE:     begin if (!cy_ok) return 0; v = cyc_cnt[31:0]; end
      A_CYCLEH:    begin if (!cy_ok) return 0; v = cyc_cnt[63:32]; end
      A_INSTRET:   begin if (!ir_ok) return 0; v = ret_cnt[31:0]; end
      A_INSTRETH:  begin if (!ir_ok) return 0; v = ret_cnt[63:32]; end
      default:     return 0;
    endcase
    return 1;
  endfunction

  function automatic bit csr_store(input logic [11:0] a, input logic [31:0] d,
                                   input logic [3:0] op);
    logic [31:0] old;
    if (a[9:8] > prv || a[11:10] == 2'b11) return 0;
    if (op == OP_SET || op == OP_CLEAR) begin
      if (!csr_fetch(a, old)) return 0;
      d = (op == OP_CLEAR) ? (old & ~d) : (old | d);
    end
    case (a)
      A_MISA, A_MIP, A_SIP: ;
      A_MSTATUS: begin
        mstat = d & MMASK;
        if ((mstat & ST_MPP) == 32'h1000) mstat &= ~ST_MPP;
      end
      A_MIE:       m_ie = d;
      A_MTVEC:     m_tvec = d & TVEC_MASK;
      A_MSCRATCH:  m_scratch = d;
      A_MEPC:      m_epc = d & EPC_MASK;
      A_MCAUSE:    m_cause = d & CAUSE_MASK;
      A_MTVAL:     m_tval = d;
      A_MEDELEG:   m_edeleg = d;
      A_MIDELEG:   m_ideleg = d;
      A_MCNTEN:    m_cnten = d & CNTEN_MASK;
      A_MCYCLE:    cyc_cnt[31:0] = d;
      A_MCYCLEH:   cyc_cnt[63:32] = d;
      A_MINSTRET:  ret_cnt[31:0] = d;
      A_MINSTRETH: ret_cnt[63:32] = d;
      A_SSTATUS:   mstat = (d & SMASK) | (mstat & ~SMASK);
      A_SIE:       s_ie = d;
      A_STVEC:     s_tvec = d & TVEC_MASK;
      A_SCNTEN:    s_cnten = d & CNTEN_MASK;
      A_SSCRATCH:  s_scratch = d;
      A_SEPC:      s_epc = d & EPC_MASK;
      A_SCAUSE:    s_cause = d & CAUSE_MASK;
      A_STVAL:     s_tval = d;
      A_SATP: begin
        if (!(prv >= 3 || !(mstat & ST_TVM))) return 0;
        s_atp = d & SATP_MASK;
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  function automatic logic [31:0] enter_trap(input logic [4:0] code, input logic intr,
                                             input logic [31:0] epc);
    logic [31:0] deleg, s, vec;
    logic [1:0]  tgt;
    deleg = intr ? m_ideleg : m_edeleg;
    tgt = deleg[code] ? PRV_S : PRV_M;
    if (tgt < prv) tgt = prv;
    if (tgt == PRV_M) begin
      s = mstat & ~(ST_MPP | ST_MPIE | ST_MIE);
      s |= 32'(prv) << 11;
      if (mstat & ST_MIE) s |= ST_MPIE;
      mstat = s;
      m_cause = {intr, 26'd0, code};
      m_epc = epc & EPC_MASK;
      vec = m_tvec;
    end else begin
      s = mstat & ~(ST_SPP | ST_SPIE | ST_SIE);
      s |= 32'(prv[0]) << 8;
      if (mstat & ST_SIE) s |= ST_SPIE;
      mstat = s;
      s_cause = {intr, 26'd0, code};
      s_epc = epc & EPC_MASK;
      vec = s_tvec;
    end
    prv = tgt;
    if (vec[0] && intr) return (vec & EPC_MASK) + 32'(code) * 4;
    return vec & EPC_MASK;
  endfunction

  function automatic res_t predict_csr_op(input item_t it);
    res_t r;
    logic [31:0] s;
    logic [1:0]  pp;
    r = '0;
    case (it.mode)
      OP_READ: begin
        r.ok = csr_fetch(it.addr, r.rdata);
        if (!r.ok) r.rdata = '0;
      end
      OP_WRITE, OP_SET, OP_CLEAR: r.ok = csr_store(it.addr, it.wdata, it.mode);
      OP_TRAP: begin
        r.target_pc = enter_trap(it.code, it.intr, it.pc);
        r.ok = 1;
      end
      OP_MRET: begin
        if (prv != PRV_M) r.target_pc = enter_trap(CAUSE_ILLEGAL, 1'b0, it.pc);
        else begin
          pp = mstat[12:11];
          s = mstat & ~(ST_MIE | ST_MPP);
          if (mstat & ST_MPIE) s |= ST_MIE;
          mstat = s | ST_MPIE;
          prv = (pp == 2'd2) ? PRV_U : pp;
          r.target_pc = m_epc;
          r.ok = 1;
        end
      end
      OP_SRET: begin
        if (prv == PRV_U || (prv == PRV_S && (mstat & ST_TSR)))
          r.target_pc = enter_trap(CAUSE_ILLEGAL, 1'b0, it.pc);
        else begin
          s = mstat & ~(ST_SIE | ST_SPP);
          prv = {1'b0, mstat[8]};
          if (mstat & ST_SPIE) s |= ST_SIE;
          mstat = s | ST_SPIE;
          r.target_pc = s_epc;
          r.ok = 1;
        end
      end
      OP_TVAL: begin
        if (prv == PRV_S) s_tval = it.wdata; else m_tval = it.wdata;
        r.ok = 1;
      end
      OP_TICK: begin
        cyc_cnt++;
        ret_cnt++;
        r.ok = 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000 | $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t make_item(input logic [3:0] m, input logic [11:0] a,
                                      input logic [31:0] d);
    item_t it;
    it.mode = m;
    it.addr = a;
    it.wdata = d;
    it.code = 5'($urandom);
    it.intr = 1'($urandom);
    it.pc = $urandom;
    return it;
  endfunction

  function automatic item_t rand_item();
    logic [11:0] a;
    int sel;
    sel = $urandom_range(0, 99);
    a = ($urandom_range(0, 9) == 0) ? 12'($urandom) : CSR_LIST[$urandom_range(0, 31)];
    if (sel < 30) return make_item(OP_READ, a, rand_word());
    if (sel < 45) return make_item(OP_WRITE, a, rand_word());
    if (sel < 52) return make_item(OP_SET, a, rand_word());
    if (sel < 59) return make_item(OP_CLEAR, a, rand_word());
    if (sel < 72) return make_item(OP_TRAP, a, rand_word());
    if (sel < 79) return make_item(OP_MRET, a, rand_word());
    if (sel < 87) return make_item(OP_SRET, a, rand_word());
    if (sel < 91) return make_item(OP_TVAL, a, rand_word());
    if (sel < 97) return make_item(OP_TICK, a, rand_word());
    return make_item(4'($urandom_range(9, 15)), a, rand_word());
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (pending_q.size() != 0 && $urandom_range(1, 100) > in_idle_pct) begin
        item_t it;
        it = pending_q.pop_front();
        in_valid <= 1;
        in_mode <= it.mode;
        in_csr_addr <= it.addr;
        in_wdata <= it.wdata;
        in_cause_code <= it.code;
        in_is_interrupt <= it.intr;
        in_pc <= it.pc;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // predict on each accepted transaction; check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        item_t it;
        it = '{in_mode, in_csr_addr, in_wdata, in_cause_code, in_is_interrupt, in_pc};
        expected_q.push_back(predict_csr_op(it));
      end
      if (out_valid && !out_stall) begin
        res_t e;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_ok !== e.ok) begin
            $error("ok exp %0h got %0h", e.ok, out_ok);
            errors++;
          end
          if (out_rdata !== e.rdata) begin
            $error("rdata exp %08h got %08h", e.rdata, out_rdata);
            errors++;
          end
          if (out_target_pc !== e.target_pc) begin
            $error("target_pc exp %08h got %08h", e.target_pc, out_target_pc);
            errors++;
          end
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(1, 100) <= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > MAX_CYCLES) begin
      $display("[riscv_csr_trap_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int ph;
    in_valid = 0; in_mode = '0; in_csr_addr = '0; in_wdata = '0;
    in_cause_code = '0; in_is_interrupt = 0; in_pc = '0; out_stall = 0;
    errors = 0; cycle = 0; in_idle_pct = 0; out_stall_pct = 0;
    prv = PRV_M; mstat = '0;
    {m_ie, m_tvec, m_scratch, m_epc, m_cause, m_tval, m_edeleg, m_ideleg, m_cnten} = '0;
    {s_ie, s_tvec, s_cnten, s_scratch, s_epc, s_cause, s_tval, s_atp} = '0;
    cyc_cnt = '0; ret_cnt = '0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // directed: counters at wrap, vectored trap, delegation, returns with TSR/TVM set
    pending_q.push_back(make_item(OP_READ, A_MISA, '0));
    pending_q.push_back(make_item(OP_WRITE, A_MCYCLE, '1));
    pending_q.push_back(make_item(OP_WRITE, A_MINSTRETH, '1));
    pending_q.push_back(make_item(OP_WRITE, A_MINSTRET, '1));
    pending_q.push_back(make_item(OP_TICK, '0, '0));
    pending_q.push_back(make_item(OP_READ, A_MINSTRET, '0));
    pending_q.push_back(make_item(OP_READ, A_MINSTRETH, '0));
    pending_q.push_back(make_item(OP_WRITE, A_MSTATUS, 32'h0040_1000 | ST_MIE | ST_SIE));
    pending_q.push_back(make_item(OP_READ, A_MSTATUS, '0));
    pending_q.push_back(make_item(OP_WRITE, A_MTVEC, '1));
    pending_q.push_back(make_item(OP_WRITE, A_STVEC, 32'h0000_1001));
    pending_q.push_back(make_item(OP_WRITE, A_MIDELEG, '1));
    pending_q.push_back(make_item(OP_WRITE, A_MEDELEG, 32'h0000_0100));
    pending_q.push_back(make_item(OP_WRITE, A_SATP, '1));
    pending_q.push_back(make_item(OP_WRITE, A_MISA, '1));
    pending_q.push_back(make_item(OP_WRITE, A_MHARTID, '1));
    pending_q.push_back('{OP_TRAP, 12'h0, 32'h0, 5'd31, 1'b1, 32'hffff_ffff});
    pending_q.push_back('{OP_MRET, 12'h0, 32'h0, 5'd0, 1'b0, 32'h0000_0101});
    pending_q.push_back('{OP_TRAP, 12'h0, 32'h0, 5'd8, 1'b0, 32'h1234_5679});
    pending_q.push_back(make_item(OP_SET, A_MSTATUS, ST_TVM | ST_TSR));
    pending_q.push_back(make_item(OP_MRET, '0, '0));
    pending_q.push_back(make_item(OP_SRET, '0, '0));
    pending_q.push_back(make_item(OP_READ, A_CYCLE, '0));
    pending_q.push_back(make_item(OP_TVAL, '0, '1));
    pending_q.push_back(make_item(4'd15, '1, '1));

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 78; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 78; end
        default: begin in_idle_pct = 10; out_stall_pct = 10; end
      endcase
      repeat (125) pending_q.push_back(rand_item());
      while (pending_q.size() != 0) @(posedge clk);
    end
    in_idle_pct = 0; out_stall_pct = 0;
    while (in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("[riscv_csr_trap_unit] OK");
    else
      $display("[riscv_csr_trap_unit] ERROR");
    $finish;
  end

endmodule
